### design/rif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the recursive iir filter unit.
// No dependencies; every other file of the block imports this package.

package rif_pkg;

  // default sizes of the block
  localparam int DEF_MAX_TAPS       = 15;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 24;

  // fixed field widths
  localparam int COEF_BITS       = 32;
  localparam int COEF_INDEX_BITS = 4;
  localparam int COUNT_BITS      = 4;
  localparam int RUN_BITS        = 8;
  localparam int CFG_INDEX_BITS  = 4;
  localparam int CFG_DATA_BITS   = 32;

  // history words carry this many bits above the sample width
  localparam int HIST_EXTRA_BITS = 16;
  // headroom of the accumulator for up to 64 product terms
  localparam int ACC_GUARD_BITS  = 6;

  // register reset values
  localparam logic [COUNT_BITS-1:0] RST_NUM_COUNT = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] RST_DEN_COUNT = COUNT_BITS'(1);
  localparam logic [RUN_BITS-1:0]   RST_RUN_LIMIT = RUN_BITS'(50);

  // request kinds
  typedef enum logic [1:0] {
    KIND_LOAD_NUM = 2'd0,
    KIND_LOAD_DEN = 2'd1,
    KIND_SAMPLE   = 2'd2,
    KIND_RESTART  = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NUM_COUNT = 4'd0,
    CFG_DEN_COUNT = 4'd1,
    CFG_GAIN      = 4'd2,
    CFG_RUN_LIMIT = 4'd3
  } cfg_reg_t;

  // operand source of one multiply term
  typedef enum logic [1:0] {
    SRC_FF   = 2'd0,
    SRC_FB   = 2'd1,
    SRC_GAIN = 2'd2
  } src_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FF,
    ST_FB_LO,
    ST_FB_HI,
    ST_DRAIN,
    ST_HROUND,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_GDRAIN,
    ST_PUSH
  } rif_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic set_y;
    logic term_valid;
    src_t term_src;
    logic term_hi;
    logic hround;
    logic push;
  } rif_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_sample;
    logic skip;
    logic out_free;
  } rif_status_t;

endpackage

`default_nettype wire

### design/rif_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the recursive iir filter unit: valid, ready and one request.
// Depends on rif_pkg for the kind type and field widths.

interface rif_item_if import rif_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                            valid;
  logic                            ready;
  kind_t                           kind;
  logic [COEF_INDEX_BITS-1:0]      coef_index;
  logic signed [COEF_BITS-1:0]     coef_value;
  logic signed [SAMPLE_BITS-1:0]   sample_in;

  modport source (output valid, kind, coef_index, coef_value, sample_in, input ready);
  modport sink (input valid, kind, coef_index, coef_value, sample_in, output ready);
endinterface

`default_nettype wire

### design/rif_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the recursive iir filter unit: valid, ready and one result.
// Depends on rif_pkg for default widths.

interface rif_result_if import rif_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
  logic                          constant_zeroed;

  modport source (output valid, sample_out, saturated, constant_zeroed, input ready);
  modport sink (input valid, sample_out, saturated, constant_zeroed, output ready);
endinterface

`default_nettype wire

### design/rif_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Configuration write channel: valid, ready, register index and write data.
// Depends on rif_pkg for the field widths.

interface rif_cfg_if import rif_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/rif_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer of the recursive iir filter unit: walks the multiply terms of one sample.
// Depends on rif_pkg for the state, command and status types.

module rif_ctrl import rif_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS,
  localparam int TI = $clog2(MAX_TAPS),
  localparam int CNT_BITS = $clog2(MAX_TAPS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rif_status_t         status,
  input  logic [CNT_BITS-1:0] num_count,
  input  logic [CNT_BITS-1:0] den_count,
  output rif_cmd_t            cmd,
  output logic [TI-1:0]       term_idx
);

  rif_state_t          state, state_next;
  logic [TI-1:0]       idx, idx_next;
  logic                ff_last, fb_last, has_fb;

  // end of tap lists
  assign ff_last = (CNT_BITS'(idx) == num_count - CNT_BITS'(1));
  assign fb_last = (CNT_BITS'(idx) == den_count - CNT_BITS'(1));
  assign has_fb  = (den_count > CNT_BITS'(1));

  // state and tap index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && status.is_sample) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.skip) begin
          state_next = ST_GAIN_LO;
        end else if (num_count != '0) begin
          state_next = ST_FF;
          idx_next   = '0;
        end else if (has_fb) begin
          state_next = ST_FB_LO;
          idx_next   = TI'(1);
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_FF: begin
        if (ff_last) begin
          if (has_fb) begin
            state_next = ST_FB_LO;
            idx_next   = TI'(1);
          end else begin
            state_next = ST_DRAIN;
          end
        end else begin
          idx_next = idx + TI'(1);
        end
      end
      ST_FB_LO: state_next = ST_FB_HI;
      ST_FB_HI: begin
        if (fb_last) begin
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_FB_LO;
          idx_next   = idx + TI'(1);
        end
      end
      ST_DRAIN:   state_next = ST_HROUND;
      ST_HROUND:  state_next = ST_GAIN_LO;
      ST_GAIN_LO: state_next = ST_GAIN_HI;
      ST_GAIN_HI: state_next = ST_GDRAIN;
      ST_GDRAIN:  state_next = ST_PUSH;
      ST_PUSH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    item_ready = (state == ST_IDLE);
    cmd.take   = item_ready && item_valid;
    unique case (state)
      ST_IDLE:   ;
      ST_DECIDE: cmd.set_y = status.skip;
      ST_FF: begin
        cmd.term_valid = 1'b1;
        cmd.term_src   = SRC_FF;
      end
      ST_FB_LO: begin
        cmd.term_valid = 1'b1;
        cmd.term_src   = SRC_FB;
      end
      ST_FB_HI: begin
        cmd.term_valid = 1'b1;
        cmd.term_src   = SRC_FB;
        cmd.term_hi    = 1'b1;
      end
      ST_DRAIN:  ;
      ST_HROUND: cmd.hround = 1'b1;
      ST_GAIN_LO: begin
        cmd.term_valid = 1'b1;
        cmd.term_src   = SRC_GAIN;
      end
      ST_GAIN_HI: begin
        cmd.term_valid = 1'b1;
        cmd.term_src   = SRC_GAIN;
        cmd.term_hi    = 1'b1;
      end
      ST_GDRAIN: ;
      ST_PUSH:   cmd.push = status.out_free;
      default:   ;
    endcase
  end

  assign term_idx = idx;

  // a load or restart request never leaves idle
  a_non_sample_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take && !status.is_sample |=> state == ST_IDLE)
    else $error("non-sample request left idle");

  // a finished result returns the sequencer to idle
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> item_ready)
    else $error("not idle after result push");

  // no request is taken while products are in flight
  a_term_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.term_valid |=> !item_ready)
    else $error("request taken during multiply terms");

endmodule

`default_nettype wire

### design/rif_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the recursive iir filter unit: tables, histories, shared multiplier,
// accumulator, rounding and saturation, result register. Depends on rif_pkg.

module rif_datapath import rif_pkg::*; #(
  parameter int MAX_TAPS       = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  localparam int TI = $clog2(MAX_TAPS),
  localparam int CNT_BITS = $clog2(MAX_TAPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rif_cmd_t                      cmd,
  input  logic [TI-1:0]                 term_idx,
  output rif_status_t                   status,
  input  kind_t                         kind,
  input  logic [COEF_INDEX_BITS-1:0]    coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [CNT_BITS-1:0]           num_count,
  input  logic [CNT_BITS-1:0]           den_count,
  input  logic signed [COEF_BITS-1:0]   gain,
  input  logic [RUN_BITS-1:0]           run_limit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated,
  output logic                          constant_zeroed
);

  localparam int HB = SAMPLE_BITS + HIST_EXTRA_BITS;
  localparam int HI_BITS = HB - SAMPLE_BITS;
  localparam int MA = ((SAMPLE_BITS > HI_BITS) ? SAMPLE_BITS : HI_BITS) + 1;
  localparam int PW = MA + COEF_BITS;
  localparam int AB = HB + COEF_BITS + ACC_GUARD_BITS;
  localparam int IW = (TI > COEF_INDEX_BITS) ? TI : COEF_INDEX_BITS;
  localparam logic signed [AB-1:0] HALF = AB'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [HB-1:0] HIST_MAX = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0] HIST_MIN = {1'b1, {(HB-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [COEF_BITS-1:0]   num_table [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   den_table [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] in_hist [MAX_TAPS];
  logic signed [HB-1:0]          out_hist [MAX_TAPS];

  logic [CNT_BITS-1:0]           position;
  logic [RUN_BITS-1:0]           repeat_count;
  logic signed [SAMPLE_BITS-1:0] last_constant;
  logic                          bypass, zeroed, clip;
  logic signed [HB-1:0]          y;
  logic signed [PW-1:0]          prod;
  logic                          prod_valid, prod_sub, prod_hi;
  logic signed [AB-1:0]          acc;

  logic take_num, take_den, take_sample, take_restart;
  logic [IW-1:0] idx_ext;

  // request decode
  assign take_num     = cmd.take && (kind == KIND_LOAD_NUM);
  assign take_den     = cmd.take && (kind == KIND_LOAD_DEN);
  assign take_sample  = cmd.take && (kind == KIND_SAMPLE);
  assign take_restart = cmd.take && (kind == KIND_RESTART);
  assign idx_ext      = IW'(coef_index);

  // coefficient tables, loads past the last tap match no entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < MAX_TAPS; e++) begin
        num_table[e] <= '0;
        den_table[e] <= '0;
      end
    end else begin
      for (int e = 0; e < MAX_TAPS; e++) begin
        if (take_num && idx_ext == IW'(e)) num_table[e] <= coef_value;
        if (take_den && idx_ext == IW'(e)) den_table[e] <= coef_value;
      end
    end
  end

  // warm-up and constant-run decision for a new sample
  logic [CNT_BITS-1:0] top_count, init;
  logic [RUN_BITS-1:0] repeat_inc, repeat_next;
  logic                bypass_next, in_run, same, zeroed_next;

  assign top_count   = (num_count > den_count) ? num_count : den_count;
  assign init        = (top_count == '0) ? '0 : top_count - CNT_BITS'(1);
  assign bypass_next = (position == '0) && (init != '0);
  assign in_run      = !bypass_next && (position >= init);
  assign same        = (sample_in == last_constant);
  assign repeat_inc  = (repeat_count == '1) ? repeat_count : repeat_count + RUN_BITS'(1);
  assign repeat_next = same ? repeat_inc : '0;
  assign zeroed_next = in_run && (repeat_next >= run_limit);

  // trace counters and per-sample flags
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      repeat_count  <= '0;
      last_constant <= '0;
      bypass        <= 1'b0;
      zeroed        <= 1'b0;
    end else if (take_restart) begin
      position      <= '0;
      repeat_count  <= '0;
      last_constant <= '0;
    end else if (take_sample) begin
      bypass <= bypass_next;
      zeroed <= zeroed_next;
      if (in_run) begin
        repeat_count <= repeat_next;
        if (!same) last_constant <= sample_in;
      end
      if (position != CNT_BITS'(MAX_TAPS)) position <= position + CNT_BITS'(1);
    end
  end

  // rounding of the accumulator and both saturations
  logic signed [AB-1:0]          rnd;
  logic                          hist_ovf, out_ovf;
  logic signed [HB-1:0]          hist_sat, y_val;
  logic signed [SAMPLE_BITS-1:0] out_sat;

  assign rnd      = (acc + HALF) >>> COEF_FRAC_BITS;
  assign hist_ovf = (|rnd[AB-1:HB-1]) && !(&rnd[AB-1:HB-1]);
  assign hist_sat = hist_ovf ? (rnd[AB-1] ? HIST_MIN : HIST_MAX) : $signed(rnd[HB-1:0]);
  assign out_ovf  = (|rnd[AB-1:SAMPLE_BITS-1]) && !(&rnd[AB-1:SAMPLE_BITS-1]);
  assign out_sat  = out_ovf ? (rnd[AB-1] ? OUT_MIN : OUT_MAX)
                            : $signed(rnd[SAMPLE_BITS-1:0]);

  // new output history word: filter result, pass-through sample or forced zero
  assign y_val = cmd.hround ? hist_sat : (bypass ? HB'(in_hist[0]) : '0);

  // sample histories, newest at entry zero
  always_ff @(posedge clk) begin
    if (rst || take_restart) begin
      for (int e = 0; e < MAX_TAPS; e++) begin
        in_hist[e]  <= '0;
        out_hist[e] <= '0;
      end
    end else if (take_sample) begin
      in_hist[0] <= sample_in;
      for (int e = 1; e < MAX_TAPS; e++) begin
        in_hist[e]  <= in_hist[e-1];
        out_hist[e] <= out_hist[e-1];
      end
    end else if (cmd.set_y || cmd.hround) begin
      out_hist[0] <= y_val;
    end
  end

  // current result and clip flag
  always_ff @(posedge clk) begin
    if (cmd.set_y || cmd.hround) y <= y_val;
    if (cmd.take) begin
      clip <= 1'b0;
    end else if (cmd.hround) begin
      clip <= clip | hist_ovf;
    end
  end

  // operand select: wide words go through as unsigned low and signed high part
  logic signed [HB-1:0]          op_word;
  logic signed [SAMPLE_BITS:0]   word_lo;
  logic signed [HI_BITS-1:0]     word_hi;
  logic signed [MA-1:0]          op_a;
  logic signed [COEF_BITS-1:0]   op_b;

  assign op_word = (cmd.term_src == SRC_GAIN) ? y : out_hist[term_idx];
  assign word_lo = {1'b0, op_word[SAMPLE_BITS-1:0]};
  assign word_hi = op_word[HB-1:SAMPLE_BITS];

  always_comb begin
    case (cmd.term_src)
      SRC_FF: begin
        op_a = MA'(in_hist[term_idx]);
        op_b = num_table[term_idx];
      end
      SRC_FB: begin
        op_a = cmd.term_hi ? MA'(word_hi) : MA'(word_lo);
        op_b = den_table[term_idx];
      end
      SRC_GAIN: begin
        op_a = cmd.term_hi ? MA'(word_hi) : MA'(word_lo);
        op_b = gain;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod     <= op_a * op_b;
    prod_sub <= (cmd.term_src == SRC_FB);
    prod_hi  <= cmd.term_hi;
    if (rst) prod_valid <= 1'b0;
    else     prod_valid <= cmd.term_valid;
  end

  // accumulator, feedback terms subtract
  logic signed [AB-1:0] addend;

  assign addend = prod_hi ? (AB'(prod) <<< SAMPLE_BITS) : AB'(prod);

  always_ff @(posedge clk) begin
    if (cmd.take || cmd.hround) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= prod_sub ? acc - addend : acc + addend;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      sample_out      <= out_sat;
      saturated       <= clip | out_ovf;
      constant_zeroed <= zeroed;
    end
  end

  assign status.is_sample = (kind == KIND_SAMPLE);
  assign status.skip      = bypass || zeroed;
  assign status.out_free  = !out_valid || out_ready;

  // a forced-zero result carries zero and no clip
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && constant_zeroed |-> sample_out == '0 && !saturated)
    else $error("forced-zero result is not zero");

  // every request starts from an empty accumulator
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> acc == '0)
    else $error("accumulator not cleared on request");

  // pass-through and forced zero exclude each other
  a_flags: assert property (@(posedge clk) disable iff (rst)
    bypass |-> !zeroed)
    else $error("pass-through and forced zero both set");

endmodule

`default_nettype wire

### design/recursive_iir_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Recursive iir filter unit, direct form I, Q8.24 coefficients and gain.
// Channels: item (requests: load numerator word, load denominator word, sample,
// restart), result (one per sample request), cfg (register writes, always ready).
// Load and restart requests give no result and leave the sequencer idle.
// A sample request walks the feed-forward terms, the feedback terms and the gain
// (a pass-through or forced-zero sample only the gain) on one
// shared multiplier, one product per cycle, feedback words in two halves
// and the gain in two halves. One sample is in work at a time; the next request
// is accepted the cycle after the result is registered.
// The result register frees the datapath: a stalled receiver only holds the
// block once a second result is ready to be written.
// Reset clears the tables, histories and trace counters and loads the register
// defaults: one tap each way, unity gain, run limit 50.
// Configuration is expected only while no sample is in work.
// Depends on rif_pkg, rif_item_if, rif_result_if, rif_cfg_if, rif_ctrl, rif_datapath.

module recursive_iir_filter_unit import rif_pkg::*; #(
  parameter int MAX_TAPS       = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  rif_item_if.sink      item,
  rif_result_if.source  result,
  rif_cfg_if.sink       cfg
);

  localparam int TI = $clog2(MAX_TAPS);
  localparam int CNT_BITS = $clog2(MAX_TAPS + 1);
  localparam logic signed [COEF_BITS-1:0] GAIN_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  logic [COUNT_BITS-1:0]       num_count, den_count;
  logic signed [COEF_BITS-1:0] gain;
  logic [RUN_BITS-1:0]         run_limit;
  logic [CNT_BITS-1:0]         num_eff, den_eff;

  rif_cmd_t      cmd;
  rif_status_t   status;
  logic [TI-1:0] term_idx;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_count <= RST_NUM_COUNT;
      den_count <= RST_DEN_COUNT;
      gain      <= GAIN_ONE;
      run_limit <= RST_RUN_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_NUM_COUNT: num_count <= cfg.data[COUNT_BITS-1:0];
        CFG_DEN_COUNT: den_count <= cfg.data[COUNT_BITS-1:0];
        CFG_GAIN:      gain      <= $signed(cfg.data[COEF_BITS-1:0]);
        CFG_RUN_LIMIT: run_limit <= cfg.data[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // counts above the table depth act as the full depth
  assign num_eff = (32'(num_count) > MAX_TAPS) ? CNT_BITS'(MAX_TAPS) : CNT_BITS'(num_count);
  assign den_eff = (32'(den_count) > MAX_TAPS) ? CNT_BITS'(MAX_TAPS) : CNT_BITS'(den_count);

  // sequencer
  rif_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .num_count  (num_eff),
    .den_count  (den_eff),
    .cmd        (cmd),
    .term_idx   (term_idx)
  );

  // arithmetic and storage
  rif_datapath #(
    .MAX_TAPS       (MAX_TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .term_idx        (term_idx),
    .status          (status),
    .kind            (item.kind),
    .coef_index      (item.coef_index),
    .coef_value      (item.coef_value),
    .sample_in       (item.sample_in),
    .num_count       (num_eff),
    .den_count       (den_eff),
    .gain            (gain),
    .run_limit       (run_limit),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .sample_out      (result.sample_out),
    .saturated       (result.saturated),
    .constant_zeroed (result.constant_zeroed)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for recursive_iir_filter_unit: coefficient loads, restarts,
// register settings and random sample traces, checked against an untimed filter model.
// Depends on rif_pkg and the rif_item_if, rif_result_if and rif_cfg_if interfaces.

module testbench;
  import rif_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 12;
  localparam int TAPS          = DEF_MAX_TAPS;
  localparam int SBITS         = DEF_SAMPLE_BITS;
  localparam int FRAC          = DEF_COEF_FRAC_BITS;
  localparam int HBITS         = DEF_SAMPLE_BITS + HIST_EXTRA_BITS;
  localparam int MAX_GAP       = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int RUN_SATURATE  = 255;

  localparam logic signed [SBITS-1:0]     SAMPLE_MAX = (1 <<< (SBITS - 1)) - 1;
  localparam logic signed [SBITS-1:0]     SAMPLE_MIN = -(1 <<< (SBITS - 1));
  localparam logic signed [COEF_BITS-1:0] COEF_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_BITS-1:0] COEF_MIN   = 32'sh8000_0000;
  localparam logic signed [COEF_BITS-1:0] UNITY_Q24  = 1 <<< FRAC;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    kind_t                       kind;
    logic [COEF_INDEX_BITS-1:0]  coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic signed [SBITS-1:0]     sample_in;
  } filt_req_t;

  typedef struct {
    logic signed [SBITS-1:0] sample_out;
    logic                    saturated;
    logic                    constant_zeroed;
  } filt_out_t;

  logic clk = 1'b0;
  logic rst;

  rif_item_if   item_ch ();
  rif_result_if res_ch ();
  rif_cfg_if    cfg_ch ();

  recursive_iir_filter_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // filter model state
  logic signed [COEF_BITS-1:0] num_coef [TAPS];
  logic signed [COEF_BITS-1:0] den_coef [TAPS];
  logic signed [SBITS-1:0]     x_hist [TAPS];
  logic signed [HBITS-1:0]     y_hist [TAPS];
  int                          trace_pos;
  int                          run_count;
  logic signed [SBITS-1:0]     run_value;

  // register copies
  logic [COUNT_BITS-1:0]       num_taps;
  logic [COUNT_BITS-1:0]       den_taps;
  logic signed [COEF_BITS-1:0] gain_q24;
  logic [RUN_BITS-1:0]         run_limit;

  filt_out_t expected_outputs [$];

  int fail_count;
  int checked_count;
  int req_count;
  int cfg_count;
  int setting_count;
  bit src_idle_on;
  bit sink_stall_on;
  logic signed [SBITS-1:0] prev_sample;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // round half up, then drop the q24 fraction
  function automatic wide_t round_q24(input wide_t a);
    return (a + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic wide_t clip_to(input wide_t a, input int bits, output logic hit);
    wide_t hi_lim, lo_lim;
    hi_lim = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
    lo_lim = -hi_lim - wide_t'(1);
    hit = 1'b0;
    if (a > hi_lim) begin
      hit = 1'b1;
      return hi_lim;
    end
    if (a < lo_lim) begin
      hit = 1'b1;
      return lo_lim;
    end
    return a;
  endfunction

  task automatic clear_trace();
    for (int i = 0; i < TAPS; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    trace_pos = 0;
    run_count = 0;
    run_value = '0;
  endtask

  task automatic model_reset();
    for (int i = 0; i < TAPS; i++) begin
      num_coef[i] = '0;
      den_coef[i] = '0;
    end
    clear_trace();
    num_taps  = RST_NUM_COUNT;
    den_taps  = RST_DEN_COUNT;
    gain_q24  = UNITY_Q24;
    run_limit = RST_RUN_LIMIT;
  endtask

  // advance the filter model by one request and queue the expected output
  task automatic predict_filter(input filt_req_t r);
    wide_t     acc, lhs, rhs, y, res;
    int        nc, dc, start_idx;
    logic      clip, zeroed, hit;
    filt_out_t o;
    case (r.kind)
      KIND_LOAD_NUM: if (r.coef_index < TAPS) num_coef[r.coef_index] = r.coef_value;
      KIND_LOAD_DEN: if (r.coef_index < TAPS) den_coef[r.coef_index] = r.coef_value;
      KIND_RESTART: clear_trace();
      KIND_SAMPLE: begin
        nc = (num_taps > TAPS) ? TAPS : num_taps;
        dc = (den_taps > TAPS) ? TAPS : den_taps;
        start_idx = (nc > dc) ? nc : dc;
        if (start_idx > 0) start_idx--;
        for (int i = TAPS - 1; i > 0; i--) begin
          x_hist[i] = x_hist[i-1];
          y_hist[i] = y_hist[i-1];
        end
        x_hist[0] = r.sample_in;
        clip   = 1'b0;
        zeroed = 1'b0;
        y      = '0;
        if (trace_pos == 0 && start_idx >= 1) begin
          // first sample of a trace goes straight through
          y = r.sample_in;
        end else begin
          // constant-input run is tracked only once warm-up is over
          if (trace_pos >= start_idx) begin
            if (r.sample_in == run_value) begin
              if (run_count < RUN_SATURATE) run_count++;
            end else begin
              run_count = 0;
              run_value = r.sample_in;
            end
            zeroed = (run_count >= run_limit);
          end
          if (!zeroed) begin
            acc = '0;
            for (int i = 0; i < nc; i++) begin
              lhs = x_hist[i];
              rhs = num_coef[i];
              acc = acc + lhs * rhs;
            end
            for (int i = 1; i < dc; i++) begin
              lhs = y_hist[i];
              rhs = den_coef[i];
              acc = acc - lhs * rhs;
            end
            y = clip_to(round_q24(acc), HBITS, hit);
            clip = hit;
          end
        end
        y_hist[0] = y[HBITS-1:0];
        if (trace_pos < TAPS) trace_pos++;
        // gain stage on the unnormalised result
        lhs = y;
        rhs = gain_q24;
        res = clip_to(round_q24(lhs * rhs), SBITS, hit);
        o.sample_out      = res[SBITS-1:0];
        o.saturated       = clip | hit;
        o.constant_zeroed = zeroed;
        expected_outputs.push_back(o);
      end
    endcase
  endtask

  // one request on the item channel; valid stays high for a back-to-back follower
  task automatic send_request(input filt_req_t r);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= r.kind;
    item_ch.coef_index <= r.coef_index;
    item_ch.coef_value <= r.coef_value;
    item_ch.sample_in  <= r.sample_in;
    do @(posedge clk); while (!item_ch.ready);
    predict_filter(r);
    req_count++;
  endtask

  function automatic filt_req_t make_req(input kind_t k, input int idx,
                                         input logic signed [COEF_BITS-1:0] coef,
                                         input logic signed [SBITS-1:0] smp);
    filt_req_t r;
    r.kind       = k;
    r.coef_index = COEF_INDEX_BITS'(idx);
    r.coef_value = coef;
    r.sample_in  = smp;
    return r;
  endfunction

  // unused fields carry random bits
  task automatic send_load(input kind_t k, input int idx, input logic signed [COEF_BITS-1:0] coef);
    send_request(make_req(k, idx, coef, SBITS'($urandom())));
  endtask

  task automatic send_sample(input logic signed [SBITS-1:0] smp);
    prev_sample = smp;
    send_request(make_req(KIND_SAMPLE, $urandom_range(0, 15), $urandom(), smp));
  endtask

  task automatic send_restart();
    send_request(make_req(KIND_RESTART, $urandom_range(0, 15), $urandom(), SBITS'($urandom())));
  endtask

  task automatic send_noise();
    send_request(make_req(kind_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom(),
                          SBITS'($urandom())));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_NUM_COUNT: num_taps  = value[COUNT_BITS-1:0];
      CFG_DEN_COUNT: den_taps  = value[COUNT_BITS-1:0];
      CFG_GAIN:      gain_q24  = value;
      CFG_RUN_LIMIT: run_limit = value[RUN_BITS-1:0];
      default: ;
    endcase
    cfg_count++;
  endtask

  // stop requests, wait for every pending output, then let the block settle
  task automatic drain_outputs(input int settle);
    item_ch.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // upper data bits are junk the block must ignore
  task automatic apply_setting(input int nc, input int dc, input logic [CFG_DATA_BITS-1:0] gain,
                               input int limit);
    logic [CFG_DATA_BITS-1:0] junk;
    drain_outputs(SETTLE_CYCLES);
    junk = $urandom();
    write_reg(CFG_NUM_COUNT, {junk[CFG_DATA_BITS-1:COUNT_BITS], COUNT_BITS'(nc)});
    junk = $urandom();
    write_reg(CFG_DEN_COUNT, {junk[CFG_DATA_BITS-1:COUNT_BITS], COUNT_BITS'(dc)});
    write_reg(CFG_GAIN, gain);
    junk = $urandom();
    write_reg(CFG_RUN_LIMIT, {junk[CFG_DATA_BITS-1:RUN_BITS], RUN_BITS'(limit)});
    cfg_ch.valid <= 1'b0;
    setting_count++;
  endtask

  // mostly small samples, with extremes, full-range values and repeats
  function automatic logic signed [SBITS-1:0] draw_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       return r[0] ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2:    return prev_sample;
      3:       return r[SBITS-1:0];
      default: return SBITS'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // feedback words kept small so most traces stay stable
  function automatic logic signed [COEF_BITS-1:0] draw_coef(input bit feedback);
    int span;
    span = feedback ? (1 << 20) : (1 << 23);
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  // reset defaults: one unity tap passes samples through
  task automatic test_pass_through();
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    send_load(KIND_LOAD_NUM, 0, UNITY_Q24);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(1);
    send_sample(-1);
    // loads past the table end are dropped, denominator slot zero is never used
    send_load(KIND_LOAD_NUM, TAPS, COEF_MAX);
    send_load(KIND_LOAD_DEN, TAPS, COEF_MIN);
    send_load(KIND_LOAD_DEN, 0, COEF_MIN);
    send_sample(5);
  endtask

  // warm-up with missing history, then a constant run that hits the limit
  task automatic test_warm_up_and_run();
    apply_setting(3, 2, COEF_MAX, 2);
    send_load(KIND_LOAD_NUM, 1, 32'sh0080_0000);
    send_load(KIND_LOAD_NUM, 2, -32'sh0040_0000);
    send_load(KIND_LOAD_DEN, 1, 32'sh0060_0000);
    send_restart();
    repeat (5) send_sample(1000);
    send_sample(-5);
  endtask

  // runaway feedback clips the stored history, negative full-scale gain
  task automatic test_history_clip();
    apply_setting(1, 2, COEF_MIN, RUN_SATURATE);
    send_load(KIND_LOAD_NUM, 0, COEF_MAX);
    send_load(KIND_LOAD_DEN, 1, COEF_MIN);
    send_restart();
    repeat (5) send_sample(SAMPLE_MAX);
  endtask

  // full taps, longest run limit and the saturating repeat counter
  task automatic test_long_constant_run();
    logic signed [SBITS-1:0] level;
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b1;
    apply_setting(TAPS, TAPS, UNITY_Q24, RUN_SATURATE);
    for (int i = 0; i < TAPS; i++) send_load(KIND_LOAD_NUM, i, $signed($urandom_range(0, 1 << 21)));
    for (int i = 1; i < TAPS; i++) send_load(KIND_LOAD_DEN, i, $signed($urandom_range(0, 1 << 18)));
    send_restart();
    level = SBITS'($urandom_range(1, 1 << 20));
    repeat (280) send_sample(level);
    send_sample(-level);
  endtask

  // traces of random content under one setting, with stray requests mixed in
  task automatic run_random_traces(input int samples);
    int sent, len;
    sent = 0;
    while (sent < samples) begin
      // usually reload the taps in use before a fresh trace
      if ($urandom_range(0, 4) != 0) begin
        for (int i = 0; i < num_taps; i++) send_load(KIND_LOAD_NUM, i, draw_coef(1'b0));
        for (int i = 1; i < den_taps; i++) send_load(KIND_LOAD_DEN, i, draw_coef(1'b1));
        send_restart();
      end
      len = $urandom_range(8, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_sample(draw_sample());
        sent++;
      end
    end
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      src_idle_on   = (p != 1) && (p != 5);
      sink_stall_on = (p != 2) && (p != 5);
      case (p)
        0: apply_setting(0, 0, COEF_MIN, 0);
        1: apply_setting(TAPS, TAPS, COEF_MAX, RUN_SATURATE);
        default: apply_setting($urandom_range(0, TAPS), $urandom_range(0, TAPS),
                               ($urandom_range(0, 3) == 0) ? $urandom()
                                 : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)),
                               ($urandom_range(0, 4) == 0) ? $urandom_range(0, RUN_SATURATE)
                                 : $urandom_range(1, 8));
      endcase
      run_random_traces((p < 2) ? 20 : 40);
    end
  endtask

  // result receiver with random stalls
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_stall_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    filt_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_outputs.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: out=%0d sat=%b zero=%b", res_ch.sample_out,
                   res_ch.saturated, res_ch.constant_zeroed);
      end else begin
        want = expected_outputs.pop_front();
        if (res_ch.sample_out !== want.sample_out || res_ch.saturated !== want.saturated ||
            res_ch.constant_zeroed !== want.constant_zeroed) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: expected out=%0d sat=%b zero=%b, got out=%0d sat=%b zero=%b",
                     checked_count, want.sample_out, want.saturated, want.constant_zeroed,
                     res_ch.sample_out, res_ch.saturated, res_ch.constant_zeroed);
        end
        checked_count++;
      end
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    model_reset();
    fail_count    = 0;
    checked_count = 0;
    req_count     = 0;
    cfg_count     = 0;
    setting_count = 0;
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    prev_sample   = '0;
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_SAMPLE;
    item_ch.coef_index <= '0;
    item_ch.coef_value <= '0;
    item_ch.sample_in  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_NUM_COUNT;
    cfg_ch.data        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_pass_through();
    test_warm_up_and_run();
    test_history_clip();
    test_long_constant_run();
    test_random_settings();

    drain_outputs(END_CYCLES);
    fail_count += expected_outputs.size();
    $display("%0d requests sent, %0d filtered samples checked, %0d mismatches",
             req_count, checked_count, fail_count);
    $display("%0d register writes over %0d settings, tap counts and gain at both extremes",
             cfg_count, setting_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
